// ===== design/rgb_to_hsl_core_assert.svh =====
// ---------------------------------------------------------------------------
// rgb_to_hsl_core assertion macros
// Clocked assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CORE_ASSERT_SVH
`define RGB_TO_HSL_CORE_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define RTH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked through reset as well.
`define RTH_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rth_pkg.sv =====
// ---------------------------------------------------------------------------
// rth_pkg
// Shared types and fixed constants of the RGB to HSL converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

   localparam int unsigned ALPHA_W   = 8;
   localparam int unsigned HUE_W     = 15;
   localparam int unsigned LEVEL_W   = 16;
   localparam int unsigned QUO_W     = 16;

   localparam int unsigned Q16_ONE   = 65535;
   localparam int unsigned HUE_SIXTH = 3840;
   localparam logic [QUO_W-1:0] HUE_FULL = 16'd23040;

   // Divider lanes
   localparam int unsigned LANES      = 2;
   localparam int unsigned LANE_HUE   = 0;
   localparam int unsigned LANE_SAT   = 1;

   typedef enum logic [1:0] {
      SRC_RED,
      SRC_GREEN,
      SRC_BLUE
   } max_src_type;

   // Side information that travels with each pixel down the pipeline
   typedef struct packed {
      logic               valid;
      logic               grey;
      logic [ALPHA_W-1:0] alpha;
      logic [LEVEL_W-1:0] light;
   } item_tag_type;

endpackage

`default_nettype wire

// ===== design/rgb_to_hsl_core.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsl_core
// RGB plus alpha to hue, saturation and lightness, one pixel per clock while the response is not stalled.
// ---------------------------------------------------------------------------
//  channel   ports                                        direction
//  request   req_valid req_stall req_red/green/blue/alpha in
//  response  rsp_valid rsp_stall rsp_hue/saturation/...   out
//
//  Throughput is one pixel per clock while the response is not stalled. The
//  pipeline holds three front stages, sixteen divider stages (one quotient
//  bit each) and the output register. Reset clears every valid bit. A stalled
//  response freezes the whole pipeline, and req_stall follows at once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_core
   import rth_pkg::*;
#(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CHANNEL_BITS-1:0] req_red,
   input  logic [CHANNEL_BITS-1:0] req_green,
   input  logic [CHANNEL_BITS-1:0] req_blue,
   input  logic [ALPHA_W-1:0]      req_alpha,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [HUE_W-1:0]        rsp_hue,
   output logic [LEVEL_W-1:0]      rsp_saturation,
   output logic [LEVEL_W-1:0]      rsp_lightness,
   output logic [ALPHA_W-1:0]      rsp_alpha_out
);

   localparam int unsigned NUM_W = CHANNEL_BITS + 18;
   localparam int unsigned DEN_W = CHANNEL_BITS + 2;

   logic             advance;
   item_tag_type     req_tag;
   item_tag_type     front_tag, div_tag;
   logic [NUM_W-1:0] front_num [LANES];
   logic [DEN_W-1:0] front_den [LANES];
   logic [QUO_W-1:0] div_quo [LANES];

   logic [QUO_W-1:0]   hue_wrap;
   logic [HUE_W-1:0]   hue_in;
   logic [LEVEL_W-1:0] sat_in;

   logic               rsp_valid_ff;
   logic [HUE_W-1:0]   rsp_hue_ff;
   logic [LEVEL_W-1:0] rsp_sat_ff, rsp_light_ff;
   logic [ALPHA_W-1:0] rsp_alpha_ff;

   // hold everything while the response transfer is stalled
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      req_tag       = '0;
      req_tag.valid = req_valid;
      req_tag.alpha = req_alpha;
   end

   rth_front #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .NUM_W        (NUM_W),
      .DEN_W        (DEN_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_tag   (req_tag),
      .in_red   (req_red),
      .in_green (req_green),
      .in_blue  (req_blue),
      .out_tag  (front_tag),
      .out_num  (front_num),
      .out_den  (front_den)
   );

   rth_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_tag  (front_tag),
      .in_num  (front_num),
      .in_den  (front_den),
      .out_tag (div_tag),
      .out_quo (div_quo)
   );

   always_comb begin
      // a hue that rounds up to a full turn wraps to zero
      hue_wrap = (div_quo[LANE_HUE] >= HUE_FULL) ? div_quo[LANE_HUE] - HUE_FULL
                                                  : div_quo[LANE_HUE];
      hue_in = div_tag.grey ? '0 : hue_wrap[HUE_W-1:0];
      sat_in = div_tag.grey ? '0 : div_quo[LANE_SAT][LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hue_ff   <= hue_in;
         rsp_sat_ff   <= sat_in;
         rsp_light_ff <= div_tag.light;
         rsp_alpha_ff <= div_tag.alpha;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_lightness  = rsp_light_ff;
   assign rsp_alpha_out  = rsp_alpha_ff;

endmodule

`default_nettype wire

// ===== design/rth_front.sv =====
// ---------------------------------------------------------------------------
// rth_front
// Three-stage front end: max/min search, difference, hue offset and the
// lightness dividend, then the numerators and denominators of the hue and
// saturation divisions and the lightness by reciprocal multiplication.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rth_front
   import rth_pkg::*;
#(
   parameter int unsigned CHANNEL_BITS = 8,
   parameter int unsigned NUM_W        = CHANNEL_BITS + 18,
   parameter int unsigned DEN_W        = CHANNEL_BITS + 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  item_tag_type            in_tag,
   input  logic [CHANNEL_BITS-1:0] in_red,
   input  logic [CHANNEL_BITS-1:0] in_green,
   input  logic [CHANNEL_BITS-1:0] in_blue,
   output item_tag_type            out_tag,
   output logic [NUM_W-1:0]        out_num [LANES],
   output logic [DEN_W-1:0]        out_den [LANES]
);

   localparam int unsigned CB    = CHANNEL_BITS;
   localparam int unsigned SUM_W = CB + 1;
   localparam int unsigned T_W   = CB + 3;
   localparam int unsigned FULL  = (1 << CB) - 1;
   localparam int unsigned SEXT_RED   = 6;
   localparam int unsigned SEXT_GREEN = 2;
   localparam int unsigned SEXT_BLUE  = 4;

   // lightness = floor(y / FULL) with y = (sum * 65535 + FULL) / 2,
   // the division done as a multiply by a rounded-up reciprocal
   localparam int unsigned X_W         = CB + 17;
   localparam int unsigned Y_W         = CB + 16;
   localparam int unsigned M_W         = Y_W + 1;
   localparam int unsigned P_W         = Y_W + M_W;
   localparam int unsigned RECIP_SHIFT = Y_W + CB;
   localparam longint unsigned LIGHT_RECIP = ((64'd1 << RECIP_SHIFT) + FULL - 1) / FULL;

   // Stage A
   item_tag_type      tag_a_ff;
   logic [CB-1:0]     red_a_ff, green_a_ff, blue_a_ff;
   logic [CB-1:0]     mx_a_ff, mn_a_ff;
   max_src_type       src_a_ff;
   logic [CB-1:0]     mx_in, mn_in;
   max_src_type       src_in;

   // Stage B
   item_tag_type      tag_b_ff, tag_b_in;
   logic [CB-1:0]     d_b_ff;
   logic [SUM_W-1:0]  den_b_ff;
   logic [T_W-1:0]    t_b_ff;
   logic [Y_W-1:0]    light_y_b_ff;
   logic [CB-1:0]     d_in;
   logic [SUM_W-1:0]  sum_in, den_in;
   logic [T_W-1:0]    t_in;
   logic [X_W-1:0]    light_x;
   logic [Y_W-1:0]    light_y_in;

   // Stage C
   item_tag_type      tag_c_ff, tag_c_in;
   logic [NUM_W-1:0]  num_c_ff [LANES];
   logic [DEN_W-1:0]  den_c_ff [LANES];
   logic [NUM_W-1:0]  num_in [LANES];
   logic [DEN_W-1:0]  den_c_in [LANES];
   logic [P_W-1:0]    light_prod;

   always_comb begin
      mx_in = in_red;
      mn_in = in_red;
      if (in_green > mx_in) mx_in = in_green;
      if (in_blue > mx_in)  mx_in = in_blue;
      if (in_green < mn_in) mn_in = in_green;
      if (in_blue < mn_in)  mn_in = in_blue;
      // ties go red, then green
      if (in_red >= in_green && in_red >= in_blue) begin
         src_in = SRC_RED;
      end else if (in_green >= in_blue) begin
         src_in = SRC_GREEN;
      end else begin
         src_in = SRC_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
      end else if (advance) begin
         tag_a_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_a_ff   <= in_red;
         green_a_ff <= in_green;
         blue_a_ff  <= in_blue;
         mx_a_ff    <= mx_in;
         mn_a_ff    <= mn_in;
         src_a_ff   <= src_in;
      end
   end

   always_comb begin
      d_in   = mx_a_ff - mn_a_ff;
      sum_in = SUM_W'(mx_a_ff) + SUM_W'(mn_a_ff);
      den_in = (sum_in > SUM_W'(FULL)) ? SUM_W'(2 * FULL) - sum_in : sum_in;
      light_x    = X_W'(sum_in) * X_W'(Q16_ONE) + X_W'(FULL);
      light_y_in = light_x[X_W-1:1];
      // hue offset in sixths of d; wraps modulo 2^T_W but ends positive
      unique case (src_a_ff)
         SRC_RED: begin
            if (green_a_ff >= blue_a_ff) begin
               t_in = T_W'(green_a_ff) - T_W'(blue_a_ff);
            end else begin
               t_in = T_W'(SEXT_RED) * T_W'(d_in) + T_W'(green_a_ff) - T_W'(blue_a_ff);
            end
         end
         SRC_GREEN: t_in = T_W'(SEXT_GREEN) * T_W'(d_in) + T_W'(blue_a_ff)
                         - T_W'(red_a_ff);
         SRC_BLUE:  t_in = T_W'(SEXT_BLUE) * T_W'(d_in) + T_W'(red_a_ff)
                         - T_W'(green_a_ff);
         default:   t_in = '0;
      endcase
   end

   always_comb begin
      tag_b_in      = tag_a_ff;
      tag_b_in.grey = (mx_a_ff == mn_a_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_b_ff <= '0;
      end else if (advance) begin
         tag_b_ff <= tag_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_b_ff       <= d_in;
         den_b_ff     <= den_in;
         t_b_ff       <= t_in;
         light_y_b_ff <= light_y_in;
      end
   end

   // Rounded quotient: (2*num + den) / (2*den)
   always_comb begin
      num_in[LANE_HUE]   = NUM_W'(t_b_ff) * NUM_W'(2 * HUE_SIXTH) + NUM_W'(d_b_ff);
      num_in[LANE_SAT]   = NUM_W'(d_b_ff) * NUM_W'(2 * Q16_ONE) + NUM_W'(den_b_ff);
      den_c_in[LANE_HUE] = DEN_W'(d_b_ff) << 1;
      den_c_in[LANE_SAT] = DEN_W'(den_b_ff) << 1;
      light_prod         = P_W'(light_y_b_ff) * P_W'(LIGHT_RECIP);
      tag_c_in           = tag_b_ff;
      tag_c_in.light     = light_prod[RECIP_SHIFT +: LEVEL_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_c_ff <= '0;
      end else if (advance) begin
         tag_c_ff <= tag_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_c_ff <= num_in;
         den_c_ff <= den_c_in;
      end
   end

   assign out_tag = tag_c_ff;
   assign out_num = num_c_ff;
   assign out_den = den_c_ff;

endmodule

`default_nettype wire

// ===== design/rth_div.sv =====
// ---------------------------------------------------------------------------
// rth_div
// Pipelined restoring divider, two lanes in lock step, one quotient bit
// per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rth_div
   import rth_pkg::*;
#(
   parameter int unsigned NUM_W = 26,
   parameter int unsigned DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  item_tag_type     in_tag,
   input  logic [NUM_W-1:0] in_num [LANES],
   input  logic [DEN_W-1:0] in_den [LANES],
   output item_tag_type     out_tag,
   output logic [QUO_W-1:0] out_quo [LANES]
);

   item_tag_type     tag_src [QUO_W];
   logic [NUM_W-1:0] rem_src [QUO_W][LANES];
   logic [DEN_W-1:0] den_src [QUO_W][LANES];
   logic [QUO_W-1:0] quo_src [QUO_W][LANES];
   logic [NUM_W-1:0] rem_in  [QUO_W][LANES];
   logic [QUO_W-1:0] quo_in  [QUO_W][LANES];

   item_tag_type     tag_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W][LANES];
   logic [NUM_W-1:0] rem_ff [QUO_W-1][LANES];
   logic [DEN_W-1:0] den_ff [QUO_W-1][LANES];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int unsigned BIT = QUO_W - 1 - s;

      if (s == 0) begin : g_head
         assign tag_src[s] = in_tag;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_src[s][l] = in_num[l];
            assign den_src[s][l] = in_den[l];
            assign quo_src[s][l] = '0;
         end
      end else begin : g_link
         assign tag_src[s] = tag_ff[s-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_src[s][l] = rem_ff[s-1][l];
            assign den_src[s][l] = den_ff[s-1][l];
            assign quo_src[s][l] = quo_ff[s-1][l];
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_step
         logic [NUM_W-1:0] trial;
         logic             take;
         assign trial = NUM_W'(den_src[s][l]) << BIT;
         assign take  = (rem_src[s][l] >= trial);
         assign rem_in[s][l] = take ? rem_src[s][l] - trial : rem_src[s][l];
         assign quo_in[s][l] = quo_src[s][l] | (QUO_W'(take) << BIT);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[s] <= '0;
         end else if (advance) begin
            tag_ff[s] <= tag_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            quo_ff[s] <= quo_in[s];
         end
      end

      // the last stage needs only the quotient
      if (s < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[s] <= rem_in[s];
               den_ff[s] <= den_src[s];
            end
         end
      end
   end

   assign out_tag = tag_ff[QUO_W-1];
   assign out_quo = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

// ===== design/rth_checker.sv =====
// ---------------------------------------------------------------------------
// rth_checker
// Port-level checks of the converter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsl_core_assert.svh"

module rth_checker
   import rth_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [HUE_W-1:0]   rsp_hue,
   input logic [LEVEL_W-1:0] rsp_saturation
);

   `RTH_ASSERT(a_hue_range, clock, reset, rsp_valid |-> rsp_hue < HUE_FULL, "hue beyond a full turn")
   `RTH_ASSERT(a_stall_source, clock, reset, req_stall |-> rsp_valid && rsp_stall, "request stalled without a stalled response")
   `RTH_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid, "response valid right after reset")
   `RTH_ASSERT(a_grey_hue, clock, reset, rsp_valid && rsp_saturation == '0 |-> rsp_hue == '0, "zero saturation with nonzero hue")
   `RTH_ASSERT(a_stall_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hue) && $stable(rsp_saturation), "stalled response changed")

endmodule

bind rgb_to_hsl_core rth_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb_rgb_to_hsl_core.sv =====
// ---------------------------------------------------------------------------
// tb_rgb_to_hsl_core
// Self-checking bench for the RGB to HSL converter. A table of directed
// pixels (extremes, greys, ties for the maximum, both saturation branches,
// near-wrap hues) comes first. Random pixels of several shapes follow. A
// local fixed-point model predicts all results but those of typed rows. Both
// channels idle at random; one long response-side hold-off backs up the pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_to_hsl_core;
   import rth_pkg::*;

   localparam int unsigned CH_BITS      = 8;
   localparam longint unsigned FULL     = (1 << CH_BITS) - 1;
   localparam int unsigned CH_MAX       = (1 << CH_BITS) - 1;
   localparam int unsigned CLK_PERIOD   = 4;
   localparam int unsigned RESET_CYCLES = 7;
   localparam int unsigned GAP_MAX      = 11;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 30;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned NUM_DIRECTED = 25;
   localparam int unsigned NUM_CHUNKS   = 6;
   localparam int unsigned CHUNK_ITEMS  = 200;

   typedef struct packed {
      logic [HUE_W-1:0]   hue;
      logic [LEVEL_W-1:0] sat;
      logic [LEVEL_W-1:0] light;
      logic [ALPHA_W-1:0] alpha;
   } hsl_result_type;

   typedef struct packed {
      logic [CH_BITS-1:0] r;
      logic [CH_BITS-1:0] g;
      logic [CH_BITS-1:0] b;
      logic [ALPHA_W-1:0] a;
      logic               typed;
      logic [HUE_W-1:0]   hue;
      logic [LEVEL_W-1:0] sat;
      logic [LEVEL_W-1:0] light;
   } pixel_row_type;

   // typed rows carry their result; the others go through the predictor
   localparam pixel_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{  0,   0,   0, 8'h00, 1,     0,     0,     0},
      '{255, 255, 255, 8'hFF, 1,     0,     0, 65535},
      '{255,   0,   0, 8'h5A, 1,     0, 65535, 32768},
      '{  0, 255,   0, 8'hA5, 1,  7680, 65535, 32768},
      '{  0,   0, 255, 8'h01, 1, 15360, 65535, 32768},
      '{255, 255,   0, 8'h80, 1,  3840, 65535, 32768},
      '{  0, 255, 255, 8'h7F, 1, 11520, 65535, 32768},
      '{255,   0, 255, 8'hFE, 1, 19200, 65535, 32768},
      '{128, 128, 128, 8'h33, 0,     0,     0,     0},
      '{  1,   1,   1, 8'hCC, 0,     0,     0,     0},
      '{254, 254, 254, 8'h0F, 0,     0,     0,     0},
      '{255,   0,   1, 8'hF0, 0,     0,     0,     0},
      '{255,   1,   0, 8'h3C, 0,     0,     0,     0},
      '{255, 200, 128, 8'hC3, 0,     0,     0,     0},
      '{200,  55, 100, 8'h11, 0,     0,     0,     0},
      '{200,  56, 100, 8'hEE, 0,     0,     0,     0},
      '{128, 127, 127, 8'h22, 0,     0,     0,     0},
      '{ 10,  11,  10, 8'hDD, 0,     0,     0,     0},
      '{ 10,  10,  11, 8'h44, 0,     0,     0,     0},
      '{254, 255, 255, 8'hBB, 0,     0,     0,     0},
      '{255, 254, 254, 8'h66, 0,     0,     0,     0},
      '{  0,   0,   1, 8'h55, 0,     0,     0,     0},
      '{255, 255, 254, 8'hAA, 0,     0,     0,     0},
      '{  1,   0,   0, 8'h99, 0,     0,     0,     0},
      '{  0, 128, 255, 8'h77, 0,     0,     0,     0}
   };

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [CH_BITS-1:0]  req_red        = '0;
   logic [CH_BITS-1:0]  req_green      = '0;
   logic [CH_BITS-1:0]  req_blue       = '0;
   logic [ALPHA_W-1:0]  req_alpha      = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [HUE_W-1:0]    rsp_hue;
   logic [LEVEL_W-1:0]  rsp_saturation;
   logic [LEVEL_W-1:0]  rsp_lightness;
   logic [ALPHA_W-1:0]  rsp_alpha_out;

   hsl_result_type      pixel_want     = '0;
   hsl_result_type      hsl_expect_q[$];
   int unsigned         mismatch_count = 0;
   int unsigned         rsp_count      = 0;
   int unsigned         idle_cycles    = 0;
   int unsigned         tx_gap_max     = GAP_MAX;
   int unsigned         rx_gap_max     = GAP_MAX;
   int unsigned         rx_hold        = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   rgb_to_hsl_core #(
      .CHANNEL_BITS (CH_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_alpha      (req_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness),
      .rsp_alpha_out  (rsp_alpha_out)
   );

   // round to nearest, halves up
   function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic hsl_result_type hsl_of_pixel(logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
                                                   logic [CH_BITS-1:0] b, logic [ALPHA_W-1:0] a);
      longint unsigned rr, gg, bb, mx, mn, d, sum, den, t;
      longint unsigned hue, sat, light;
      hsl_result_type  res;
      rr = 64'(r);
      gg = 64'(g);
      bb = 64'(b);
      mx = rr;
      if (gg > mx) mx = gg;
      if (bb > mx) mx = bb;
      mn = rr;
      if (gg < mn) mn = gg;
      if (bb < mn) mn = bb;
      d     = mx - mn;
      sum   = mx + mn;
      light = round_div(sum * Q16_ONE, 2 * FULL);
      hue   = 0;
      sat   = 0;
      if (d != 0) begin
         den = (sum > FULL) ? (2 * FULL - sum) : sum;
         sat = round_div(d * Q16_ONE, den);
         // ties go red, then green
         if (mx == rr) begin
            t = (gg >= bb) ? (gg - bb) : (6 * d - (bb - gg));
         end else if (mx == gg) begin
            t = 2 * d + bb - rr;
         end else begin
            t = 4 * d + rr - gg;
         end
         hue = round_div(t * HUE_SIXTH, d);
         if (hue >= HUE_FULL) hue -= HUE_FULL;
      end
      res.hue   = hue[HUE_W-1:0];
      res.sat   = sat[LEVEL_W-1:0];
      res.light = light[LEVEL_W-1:0];
      res.alpha = a;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: MISMATCH on pixel %0d: %s", $time, rsp_count, what);
      mismatch_count++;
   endtask

   // Offer one pixel after a random gap and hold it until the transfer.
   task automatic offer_pixel(input logic [CH_BITS-1:0] r, input logic [CH_BITS-1:0] g,
                              input logic [CH_BITS-1:0] b, input logic [ALPHA_W-1:0] a,
                              input hsl_result_type want);
      int unsigned gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_red    <= r;
      req_green  <= g;
      req_blue   <= b;
      req_alpha  <= a;
      pixel_want <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // Response side: random stall per item, plus one long hold on request.
   initial begin
      int unsigned wait_n;
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold != 0) begin
            wait_n  = rx_hold;
            rx_hold = 0;
         end else begin
            wait_n = $urandom_range(0, rx_gap_max);
         end
         if (wait_n != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Check responses, record accepted pixels, watch for a hang.
   always @(posedge clock) begin
      hsl_result_type want;
      logic           moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (hsl_expect_q.size() == 0) begin
               report_mismatch("response with no pixel outstanding");
            end else begin
               want = hsl_expect_q.pop_front();
               if (rsp_hue !== want.hue)
                  report_mismatch($sformatf("hue got %0d, expected %0d", rsp_hue, want.hue));
               if (rsp_saturation !== want.sat)
                  report_mismatch($sformatf("saturation got %0d, expected %0d",
                                            rsp_saturation, want.sat));
               if (rsp_lightness !== want.light)
                  report_mismatch($sformatf("lightness got %0d, expected %0d",
                                            rsp_lightness, want.light));
               if (rsp_alpha_out !== want.alpha)
                  report_mismatch($sformatf("alpha got %0d, expected %0d",
                                            rsp_alpha_out, want.alpha));
            end
            rsp_count++;
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            hsl_expect_q.push_back(pixel_want);
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      pixel_row_type      row;
      hsl_result_type     want;
      logic [CH_BITS-1:0] r, g, b, hi, lo, base;
      logic [ALPHA_W-1:0] a;
      logic [1:0]         sel;
      int unsigned        shape, k;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.typed) begin
            want.hue   = row.hue;
            want.sat   = row.sat;
            want.light = row.light;
            want.alpha = row.a;
         end else begin
            want = hsl_of_pixel(row.r, row.g, row.b, row.a);
         end
         offer_pixel(row.r, row.g, row.b, row.a, want);
      end

      for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
         case (chunk)
            1: begin
               tx_gap_max = 0;
               rx_gap_max = 0;
            end
            2: begin
               // back up the pipeline while the sender keeps offering
               tx_gap_max = 0;
               rx_hold    = HOLD_CYCLES;
            end
            3: begin
               tx_gap_max = GAP_MAX;
               rx_gap_max = 0;
            end
            4: begin
               tx_gap_max = 0;
               rx_gap_max = GAP_MAX;
            end
            default: begin
               tx_gap_max = GAP_MAX;
               rx_gap_max = GAP_MAX;
            end
         endcase
         for (int n = 0; n < CHUNK_ITEMS; n++) begin
            shape = $urandom_range(0, 9);
            r     = CH_BITS'($urandom_range(0, CH_MAX));
            g     = CH_BITS'($urandom_range(0, CH_MAX));
            b     = CH_BITS'($urandom_range(0, CH_MAX));
            a     = ALPHA_W'($urandom_range(0, 255));
            case (shape)
               5: begin
                  g = r;
                  b = r;
               end
               6: begin
                  // two channels share the maximum
                  hi = CH_BITS'($urandom_range(1, CH_MAX));
                  lo = CH_BITS'($urandom_range(0, 32'(hi) - 1));
                  k  = $urandom_range(0, 2);
                  r  = (k == 0) ? lo : hi;
                  g  = (k == 1) ? lo : hi;
                  b  = (k == 2) ? lo : hi;
               end
               7: begin
                  sel = 2'($urandom_range(0, 3));
                  r   = {{(CH_BITS-1){sel[1]}}, sel[0]};
                  sel = 2'($urandom_range(0, 3));
                  g   = {{(CH_BITS-1){sel[1]}}, sel[0]};
                  sel = 2'($urandom_range(0, 3));
                  b   = {{(CH_BITS-1){sel[1]}}, sel[0]};
               end
               8: begin
                  base = CH_BITS'($urandom_range(0, CH_MAX - 5));
                  r    = base + CH_BITS'($urandom_range(0, 5));
                  g    = base + CH_BITS'($urandom_range(0, 5));
                  b    = base + CH_BITS'($urandom_range(0, 5));
               end
               9: begin
                  k  = $urandom_range(0, 2);
                  hi = ($urandom_range(0, 1) != 0) ? CH_BITS'(CH_MAX) : '0;
                  if (k == 0) r = hi;
                  else if (k == 1) g = hi;
                  else b = hi;
               end
               default: ;
            endcase
            offer_pixel(r, g, b, a, hsl_of_pixel(r, g, b, a));
         end
      end
      req_valid <= 1'b0;

      while (hsl_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== rgb_to_hsl_core.f =====
+incdir+design
design/rth_pkg.sv
design/rth_front.sv
design/rth_div.sv
design/rgb_to_hsl_core.sv
design/rth_checker.sv
tb/tb_rgb_to_hsl_core.sv
